>>> src/rita_pkg.sv
// types, constants and control store of the radix integer to ascii converter
`default_nettype none

package rita_pkg;

   // radix selector codes
   localparam logic [1:0] FUNC_BIN     = 2'd0;
   localparam logic [1:0] FUNC_DEC     = 2'd1;
   localparam logic [1:0] FUNC_HEX     = 2'd2;
   localparam logic [1:0] FUNC_HEX_ALT = 2'd3;

   // ascii codes
   localparam logic [6:0] CHAR_ZERO   = 7'd48;
   localparam logic [6:0] CHAR_MINUS  = 7'd45;
   localparam logic [6:0] CHAR_LETTER = 7'd55;

   typedef logic [2:0] step_type;

   // step addresses of the control program
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_DABBLE = 3'd1;
   localparam step_type STEP_SCAN   = 3'd2;
   localparam step_type STEP_SIGN   = 3'd3;
   localparam step_type STEP_PAD    = 3'd4;
   localparam step_type STEP_DIGIT  = 3'd5;

   typedef enum logic [2:0] {
      OP_WAIT   = 3'd0,
      OP_DABBLE = 3'd1,
      OP_SCAN   = 3'd2,
      OP_SIGN   = 3'd3,
      OP_PAD    = 3'd4,
      OP_DIGIT  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      COND_START  = 3'd0,
      COND_DABBLE = 3'd1,
      COND_SCAN   = 3'd2,
      COND_PAD    = 3'd3,
      COND_MORE   = 3'd4,
      COND_NEVER  = 3'd5
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump_true;
      step_type jump_false;
   } ucode_type;

   // control store: one word per step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_IDLE:   word = '{OP_WAIT,   COND_START,  STEP_DABBLE, STEP_IDLE};
         STEP_DABBLE: word = '{OP_DABBLE, COND_DABBLE, STEP_DABBLE, STEP_SCAN};
         STEP_SCAN:   word = '{OP_SCAN,   COND_SCAN,   STEP_SCAN,   STEP_SIGN};
         STEP_SIGN:   word = '{OP_SIGN,   COND_NEVER,  STEP_PAD,    STEP_PAD};
         STEP_PAD:    word = '{OP_PAD,    COND_PAD,    STEP_PAD,    STEP_DIGIT};
         STEP_DIGIT:  word = '{OP_DIGIT,  COND_MORE,   STEP_DIGIT,  STEP_IDLE};
         default:     word = '{OP_WAIT,   COND_NEVER,  STEP_IDLE,   STEP_IDLE};
      endcase
      return word;
   endfunction

   // digit value to ascii, uppercase letters
   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] code;
      if (d < 4'd10) begin
         code = {3'b000, d} + CHAR_ZERO;
      end else begin
         code = {3'b000, d} + CHAR_LETTER;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

>>> src/radix_integer_to_ascii.sv
// top level: microcoded integer to ascii converter for radix 2, 10 and 16
`default_nettype none

// Converts one number per transaction into ASCII text, one character per
// rsp_strobe pulse, with rsp_last on the final character. A transaction is
// taken when start is high while busy is low; busy stays high until the last
// character has gone out, and the receiver cannot stall the output, so each
// character must be captured in the cycle its strobe is high. Work is run by a
// six-step control program with a step counter. A transaction is loaded, then
// for decimal goes through shift-and-add-3 conversion (binary and hex need
// none), then a leading-zero scan drops leading zero digits, then the sign,
// the pad characters and the digits are sent. The decimal conversion pass, the
// digit scan and the padding set how long a transaction runs.
module radix_integer_to_ascii #(
   parameter int VALUE_WIDTH    = 32,
   parameter int MAX_PAD_DIGITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic [1:0]             req_func,
   input  wire logic                   req_signed_mode,
   input  wire logic [5:0]             req_min_digits,
   output logic                        rsp_strobe,
   output logic [6:0]                  rsp_char_out,
   output logic                        rsp_last
);

   // digit slot counts per radix
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int HEXW       = 4 * HEX_DIGITS;
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DIGW       = 4 * VALUE_WIDTH;
   // place count holds up to VALUE_WIDTH, index reaches VALUE_WIDTH-1
   localparam int PLW        = $clog2(VALUE_WIDTH + 1);
   localparam int IDXW       = $clog2(VALUE_WIDTH);
   localparam int CMPW       = ((PLW > 6) ? PLW : 6) + 1;

   // sequencer and output registers
   rita_pkg::step_type      pc_ff, pc_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [6:0]              rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   // datapath registers
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;     // binary shifted into the bcd slots
   logic [DIGW-1:0]         digs_ff, digs_in;       // one 4-bit slot per digit
   logic                    is_dec_ff, is_dec_in;
   logic                    neg_ff, neg_in;
   logic [5:0]              pad_ff, pad_in;
   logic [PLW-1:0]          cnt_ff, cnt_in;         // dabble iterations left
   logic [PLW-1:0]          places_ff, places_in;   // significant digits still to send
   logic [5:0]              chars_left_ff, chars_left_in;

   // combinational helpers
   rita_pkg::ucode_type     uword;
   logic                    cond_hit;
   logic                    neg_load;
   logic [VALUE_WIDTH-1:0]  mag;
   logic [HEXW-1:0]         mag_ext;
   logic [DIGW-1:0]         bin_digs;
   logic [DIGW-1:0]         adj_digs;
   logic [IDXW-1:0]         places_idx;
   logic [3:0]              cur_digit;
   logic [CMPW-1:0]         used;
   logic [CMPW-1:0]         pad_wide;

   assign busy         = (pc_ff != rita_pkg::STEP_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // magnitude of the incoming number
   assign neg_load = req_signed_mode & req_value[VALUE_WIDTH-1];
   assign mag      = neg_load ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign mag_ext  = HEXW'(mag);

   // binary: one bit per slot
   always_comb begin
      for (int k = 0; k < VALUE_WIDTH; k++) begin
         bin_digs[k*4 +: 4] = {3'b000, mag[k]};
      end
   end

   // add 3 to every bcd slot of 5 or more before the shift
   always_comb begin
      for (int k = 0; k < VALUE_WIDTH; k++) begin
         adj_digs[k*4 +: 4] = (digs_ff[k*4 +: 4] >= 4'd5) ?
                              (digs_ff[k*4 +: 4] + 4'd3) : digs_ff[k*4 +: 4];
      end
   end

   // most significant digit still to send
   assign places_idx = IDXW'(places_ff - PLW'(1));
   assign cur_digit  = digs_ff[{places_idx, 2'b00} +: 4];

   // text length so far: digits plus the sign
   assign used     = CMPW'(places_ff) + CMPW'(neg_ff);
   assign pad_wide = CMPW'(pad_ff);

   // sequencer: fetch, test condition, execute
   always_comb begin
      uword = rita_pkg::ucode_rom(pc_ff);

      unique case (uword.cond)
         rita_pkg::COND_START:  cond_hit = start;
         rita_pkg::COND_DABBLE: cond_hit = is_dec_ff && (cnt_ff != '0);
         rita_pkg::COND_SCAN:   cond_hit = (places_ff > PLW'(1)) && (cur_digit == 4'd0);
         rita_pkg::COND_PAD:    cond_hit = (chars_left_ff != 6'd0);
         rita_pkg::COND_MORE:   cond_hit = (places_ff != PLW'(1));
         default:               cond_hit = 1'b0;
      endcase

      pc_in         = cond_hit ? uword.jump_true : uword.jump_false;
      value_in      = value_ff;
      digs_in       = digs_ff;
      is_dec_in     = is_dec_ff;
      neg_in        = neg_ff;
      pad_in        = pad_ff;
      cnt_in        = cnt_ff;
      places_in     = places_ff;
      chars_left_in = chars_left_ff;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = 1'b0;

      unique case (uword.op)
         rita_pkg::OP_WAIT: begin
            if (cond_hit) begin
               neg_in    = neg_load;
               value_in  = mag;
               cnt_in    = PLW'(VALUE_WIDTH);
               pad_in    = (req_min_digits > 6'(MAX_PAD_DIGITS)) ?
                           6'(MAX_PAD_DIGITS) : req_min_digits;
               unique case (req_func) inside
                  rita_pkg::FUNC_BIN: begin
                     is_dec_in = 1'b0;
                     digs_in   = bin_digs;
                     places_in = PLW'(VALUE_WIDTH);
                  end
                  rita_pkg::FUNC_DEC: begin
                     is_dec_in = 1'b1;
                     digs_in   = '0;
                     places_in = PLW'(DEC_DIGITS);
                  end
                  rita_pkg::FUNC_HEX, rita_pkg::FUNC_HEX_ALT: begin
                     is_dec_in = 1'b0;
                     digs_in   = DIGW'(mag_ext);
                     places_in = PLW'(HEX_DIGITS);
                  end
                  default: begin
                     is_dec_in = 1'b0;
                     digs_in   = DIGW'(mag_ext);
                     places_in = PLW'(HEX_DIGITS);
                  end
               endcase
            end
         end
         rita_pkg::OP_DABBLE: begin
            // one bit of the binary value into the bcd slots
            if (cond_hit) begin
               digs_in  = {adj_digs[DIGW-2:0], value_ff[VALUE_WIDTH-1]};
               value_in = value_ff << 1;
               cnt_in   = cnt_ff - PLW'(1);
            end
         end
         rita_pkg::OP_SCAN: begin
            // drop a leading zero digit, keep at least one
            if (cond_hit) begin
               places_in = places_ff - PLW'(1);
            end
         end
         rita_pkg::OP_SIGN: begin
            chars_left_in = (pad_wide > used) ? 6'(pad_wide - used) : 6'd0;
            if (neg_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_char_in   = rita_pkg::CHAR_MINUS;
            end
         end
         rita_pkg::OP_PAD: begin
            if (cond_hit) begin
               rsp_strobe_in = 1'b1;
               rsp_char_in   = rita_pkg::CHAR_ZERO;
               chars_left_in = chars_left_ff - 6'd1;
            end
         end
         rita_pkg::OP_DIGIT: begin
            rsp_strobe_in = 1'b1;
            rsp_char_in   = rita_pkg::digit_char(cur_digit);
            rsp_last_in   = (places_ff == PLW'(1));
            places_in     = places_ff - PLW'(1);
         end
         default: begin
            pc_in = rita_pkg::STEP_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= rita_pkg::STEP_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath and output payload
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      digs_ff       <= digs_in;
      is_dec_ff     <= is_dec_in;
      neg_ff        <= neg_in;
      pad_ff        <= pad_in;
      cnt_ff        <= cnt_in;
      places_ff     <= places_in;
      chars_left_ff <= chars_left_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

>>> bench/tb.sv
// testbench for the radix integer to ascii converter: directed table plus random numbers
`timescale 1ns / 1ps

module tb;

   localparam int MAX_PAD       = 32;   // minimum count saturates here
   localparam int DIRECTED_ROWS = 24;
   localparam int PHASE_ITEMS   = 24;   // four phases of random numbers
   localparam int DRAIN_CYCLES  = 150;  // longer than one full 33-character number

   // one number to convert, as it goes onto the req_ ports
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  func;
      logic        sgn;
      logic [5:0]  min_digits;
   } number_req_type;

   // one ascii character as it should appear on the rsp_ ports
   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } text_char_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_value;
   logic [1:0]  req_func;
   logic        req_signed_mode;
   logic [5:0]  req_min_digits;
   logic        rsp_strobe;
   logic [6:0]  rsp_char_out;
   logic        rsp_last;

   text_char_type expected_text [$];   // characters still owed by the block, oldest first
   int            mismatch_count = 0;

   // directed numbers: extremes of every field, each radix, the special cases
   number_req_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h0000_0000, rita_pkg::FUNC_BIN,     1'b0, 6'd0},   // zero in every radix
      '{32'h0000_0000, rita_pkg::FUNC_DEC,     1'b0, 6'd0},
      '{32'h0000_0000, rita_pkg::FUNC_HEX,     1'b0, 6'd5},   // zero padded
      '{32'hFFFF_FFFF, rita_pkg::FUNC_HEX,     1'b0, 6'd0},
      '{32'hFFFF_FFFF, rita_pkg::FUNC_DEC,     1'b0, 6'd0},
      '{32'hFFFF_FFFF, rita_pkg::FUNC_DEC,     1'b1, 6'd0},   // minus one
      '{32'h8000_0000, rita_pkg::FUNC_DEC,     1'b1, 6'd0},   // most negative value
      '{32'h8000_0000, rita_pkg::FUNC_HEX,     1'b1, 6'd0},
      '{32'h8000_0000, rita_pkg::FUNC_BIN,     1'b1, 6'd0},   // longest text: sign plus 32 digits
      '{32'hFFFF_FFFF, rita_pkg::FUNC_BIN,     1'b0, 6'd0},
      '{32'h7FFF_FFFF, rita_pkg::FUNC_DEC,     1'b1, 6'd0},   // largest positive in signed mode
      '{32'hABCD_EF12, rita_pkg::FUNC_HEX_ALT, 1'b0, 6'd0},   // selector three reads as hex
      '{32'h0000_0005, rita_pkg::FUNC_DEC,     1'b0, 6'd63},  // minimum count saturates
      '{32'h0000_0005, rita_pkg::FUNC_DEC,     1'b0, 6'd33},
      '{32'h0000_3039, rita_pkg::FUNC_DEC,     1'b0, 6'd3},   // count below text length, no cut
      '{32'hFFFF_FFF6, rita_pkg::FUNC_DEC,     1'b1, 6'd4},   // padding goes after the sign
      '{32'h0000_0000, rita_pkg::FUNC_DEC,     1'b1, 6'd0},
      '{32'h0000_000A, rita_pkg::FUNC_BIN,     1'b0, 6'd0},
      '{32'h0000_003C, rita_pkg::FUNC_HEX,     1'b0, 6'd1},
      '{32'hFFFF_FFFF, rita_pkg::FUNC_DEC,     1'b1, 6'd32},
      '{32'h8000_0000, rita_pkg::FUNC_BIN,     1'b1, 6'd63},  // saturated count below text length
      '{32'h0000_FFFF, rita_pkg::FUNC_HEX_ALT, 1'b1, 6'd2},   // positive number in signed mode
      '{32'h0000_0009, rita_pkg::FUNC_DEC,     1'b0, 6'd1},
      '{32'h7FFF_FFFF, rita_pkg::FUNC_BIN,     1'b1, 6'd40}
   };

   // text read straight off the number; empty means the predictor supplies it
   string directed_text [DIRECTED_ROWS] = '{
      "0", "0", "00000", "FFFFFFFF", "4294967295", "-1", "-2147483648",
      "-80000000", "", "", "2147483647", "ABCDEF12", "", "", "12345", "-010",
      "0", "1010", "3C", "", "", "FFFF", "9", ""
   };

   radix_integer_to_ascii u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_func        (req_func),
      .req_signed_mode (req_signed_mode),
      .req_min_digits  (req_min_digits),
      .rsp_strobe      (rsp_strobe),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // works out the text of one number and queues it character by character
   function automatic void queue_number_text(input number_req_type req);
      logic [31:0]   magnitude;
      logic [31:0]   rest;
      logic [31:0]   radix;
      logic [3:0]    digits [32];
      logic          negative;
      int            places;
      int            pad_to;
      int            k;
      text_char_type c;

      case (req.func)
         rita_pkg::FUNC_BIN: radix = 32'd2;
         rita_pkg::FUNC_DEC: radix = 32'd10;
         default:            radix = 32'd16;   // hex and the spare selector
      endcase
      pad_to = (req.min_digits > MAX_PAD) ? MAX_PAD : int'(req.min_digits);

      // two's complement negation leaves the most negative value as its own magnitude
      negative  = req.sgn && req.value[31];
      magnitude = negative ? -req.value : req.value;

      // digits least significant first; zero still yields one digit
      places = 0;
      rest   = magnitude;
      do begin
         digits[places] = 4'(rest % radix);
         rest = rest / radix;
         places++;
      end while (rest != 0);

      if (negative) begin
         c = '{rita_pkg::CHAR_MINUS, 1'b0};
         expected_text.push_back(c);
      end
      // pad counts the sign as part of the text
      for (k = places + int'(negative); k < pad_to; k++) begin
         c = '{rita_pkg::CHAR_ZERO, 1'b0};
         expected_text.push_back(c);
      end
      for (k = places - 1; k >= 0; k--) begin
         c.ch   = (digits[k] < 4'd10) ? ({3'b000, digits[k]} + rita_pkg::CHAR_ZERO)
                                      : ({3'b000, digits[k]} + rita_pkg::CHAR_LETTER);
         c.last = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   // random number biased toward the interesting corners
   function automatic number_req_type random_number();
      number_req_type req;
      case ($urandom_range(5))
         0: req.value = $urandom;
         1: req.value = $urandom_range(20);                     // short texts
         2: req.value = 32'h8000_0000 | $urandom;                // negative when signed
         3: req.value = -$urandom_range(1, 1000);               // small negatives
         4: req.value = $urandom >> $urandom_range(31);         // every length
         default: begin
            case ($urandom_range(3))
               0: req.value = 32'h0000_0000;
               1: req.value = 32'hFFFF_FFFF;
               2: req.value = 32'h8000_0000;
               default: req.value = 32'h7FFF_FFFF;
            endcase
         end
      endcase
      req.func       = 2'($urandom_range(3));
      req.sgn        = 1'($urandom_range(1));
      // mostly modest padding, now and then anything the port allows
      req.min_digits = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                : 6'($urandom_range(12));
      return req;
   endfunction

   // put a number on the ports at the falling edge and hold it until a
   // rising edge sees start with busy low; start stays high on return so the
   // next falling edge decides whether it stays or drops
   task automatic send_number(input number_req_type req);
      @(negedge clock);
      start           <= 1'b1;
      req_value       <= req.value;
      req_func        <= req.func;
      req_signed_mode <= req.sgn;
      req_min_digits  <= req.min_digits;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // one cycle with start low; the fields carry noise the block must ignore
   task automatic idle_cycle();
      @(negedge clock);
      start           <= 1'b0;
      req_value       <= $urandom;
      req_func        <= 2'($urandom_range(3));
      req_signed_mode <= 1'($urandom_range(1));
      req_min_digits  <= 6'($urandom_range(63));
   endtask

   // response checker: the receiver cannot stall, so every strobe is a
   // character that must match the oldest one still owed
   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                     $time, rsp_char_out, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_char_out !== want.ch) begin
               $display("%0t: char mismatch: expected %0d, actual %0d",
                        $time, want.ch, rsp_char_out);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int             gap_pct [4];
      int             i;
      int             p;
      int             k;
      number_req_type req;
      text_char_type  c;
      string          s;

      gap_pct[0] = 0;
      gap_pct[1] = 86;
      gap_pct[2] = 8;
      gap_pct[3] = 0;

      // every input known from time zero
      reset           = 1'b1;
      start           = 1'b0;
      req_value       = '0;
      req_func        = rita_pkg::FUNC_BIN;
      req_signed_mode = 1'b0;
      req_min_digits  = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, back to back
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_number(directed_rows[i]);
         s = directed_text[i];
         if (s.len() != 0) begin
            for (k = 0; k < s.len(); k++) begin
               c.ch   = 7'(s[k]);
               c.last = (k == s.len() - 1);
               expected_text.push_back(c);
            end
         end else begin
            queue_number_text(directed_rows[i]);
         end
      end

      // random numbers in phases: no sender gaps, sender idle most of the
      // time, sender idle now and then, then no gaps again; the receiver
      // has no stall input, so its idling has nothing to act on
      for (p = 0; p < 4; p++) begin
         for (i = 0; i < PHASE_ITEMS; i++) begin
            while ($urandom_range(99) < gap_pct[p]) idle_cycle();
            req = random_number();
            send_number(req);
            queue_number_text(req);
         end
      end
      idle_cycle();

      // drain: every owed character, then a margin for stray strobes
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
